// ----- hdl/agc_pkg.sv -----
// Package for the anagram group classifier.
// Holds item structs, the letter histogram type, the query record and count limits.
// No dependencies.
`default_nettype none

package agc_pkg;

    localparam int ALPHABET        = 26;
    localparam int LETTER_W        = 5;
    localparam int CNT_W           = 4;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam int GROUP_IDX_W     = 8;
    localparam int MAX_GROUPS_DEF   = 16;
    localparam int MAX_WORD_LEN_DEF = 15;

    typedef logic [ALPHABET-1:0][CNT_W-1:0] hist_t;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                word_end;
    } in_item_t;

    typedef struct packed {
        logic [3:0] group_index;
        logic       new_group;
        logic [3:0] member_position;
        logic       table_full;
    } out_item_t;

    typedef struct packed {
        logic                   valid;
        logic                   done;
        logic                   new_grp;
        logic [GROUP_IDX_W-1:0] idx;
        logic [CNT_W-1:0]       pos;
        hist_t                  hist;
    } query_t;

endpackage

`default_nettype wire

// ----- hdl/anagram_group_classifier.sv -----
// Top level of the anagram group classifier: histogram, chain of group cells, result register.
// Depends on agc_pkg, agc_hist and agc_cell.
//
//  channel | ports               | payload     | direction
//  s_      | s_valid s_ready     | in_item_t   | letters in
//  m_      | m_valid m_ready     | out_item_t  | one result per finished word
//
// Letters and words stream back to back unless a stalled result holds the input.
// A finished word walks the chain one cell per cycle unless the result stalls, passing
// through every cell's query register and then the result register before it appears.
// Reset clears the histogram, all cell used flags and the pipeline.
// A stalled result holds the whole chain and the input until it is taken.
`default_nettype none

module anagram_group_classifier #(
    parameter int MAX_GROUPS   = agc_pkg::MAX_GROUPS_DEF,
    parameter int MAX_WORD_LEN = agc_pkg::MAX_WORD_LEN_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire agc_pkg::in_item_t   s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output agc_pkg::out_item_t       m_data
);

    logic                 advance;
    logic                 take;
    agc_pkg::hist_t       hist_now;
    agc_pkg::query_t      chain [MAX_GROUPS+1];
    logic                 m_valid_reg;
    agc_pkg::out_item_t   m_data_reg;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;
    assign take    = s_valid && advance;

    agc_hist #(
        .MAX_WORD_LEN(MAX_WORD_LEN)
    ) u_hist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (take),
        .letter   (s_data.letter),
        .word_end (s_data.word_end),
        .hist_now (hist_now)
    );

    always_comb begin
        chain[0]         = '0;
        chain[0].valid   = take && s_data.word_end;
        chain[0].hist    = hist_now;
    end

    for (genvar g = 0; g < MAX_GROUPS; g++) begin : g_cell
        agc_cell #(
            .CELL_INDEX(g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .q_in    (chain[g]),
            .q_out   (chain[g+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= chain[MAX_GROUPS].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (chain[MAX_GROUPS].done) begin
                m_data_reg.group_index     <= chain[MAX_GROUPS].idx[3:0];
                m_data_reg.new_group       <= chain[MAX_GROUPS].new_grp;
                m_data_reg.member_position <= chain[MAX_GROUPS].pos;
                m_data_reg.table_full      <= 1'b0;
            end else begin
                m_data_reg.group_index     <= '0;
                m_data_reg.new_group       <= 1'b0;
                m_data_reg.member_position <= '0;
                m_data_reg.table_full      <= 1'b1;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ----- hdl/agc_hist.sv -----
// Letter histogram accumulator for the anagram group classifier.
// Counts letters of the current word and presents the histogram including the item
// being taken. Depends on agc_pkg.
`default_nettype none

module agc_hist #(
    parameter int MAX_WORD_LEN = agc_pkg::MAX_WORD_LEN_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          take,
    input  wire logic [agc_pkg::LETTER_W-1:0]  letter,
    input  wire logic                          word_end,
    output agc_pkg::hist_t                     hist_now
);

    localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);

    agc_pkg::hist_t   counts_reg;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             counted;

    always_comb begin
        hist_now = counts_reg;
        counted  = (letter < agc_pkg::LETTER_W'(agc_pkg::ALPHABET))
                   && (len_reg < LEN_W'(MAX_WORD_LEN));
        len_next = len_reg;
        if (counted) begin
            len_next = len_reg + LEN_W'(1);
            for (int i = 0; i < agc_pkg::ALPHABET; i++) begin
                if (letter == agc_pkg::LETTER_W'(i)
                        && counts_reg[i] != agc_pkg::COUNT_MAX) begin
                    hist_now[i] = counts_reg[i] + agc_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counts_reg <= '0;
            len_reg    <= '0;
        end else if (take) begin
            if (word_end) begin
                counts_reg <= '0;
                len_reg    <= '0;
            end else begin
                counts_reg <= hist_now;
                len_reg    <= len_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/agc_cell.sv -----
// One group cell of the classifier chain: signature, member count and a query stage.
// Matches or opens its group for a passing query, then hands the query on.
// Depends on agc_pkg.
`default_nettype none

module agc_cell #(
    parameter int CELL_INDEX = 0
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           advance,
    input  wire agc_pkg::query_t q_in,
    output agc_pkg::query_t     q_out
);

    agc_pkg::hist_t               sig_reg;
    logic [agc_pkg::CNT_W-1:0]    size_reg, size_next;
    logic                         used_reg, used_next;
    logic                         store;
    agc_pkg::query_t              q_reg, q_next;

    always_comb begin
        q_next    = q_in;
        size_next = size_reg;
        used_next = used_reg;
        store     = 1'b0;
        if (q_in.valid && !q_in.done) begin
            if (used_reg) begin
                if (sig_reg == q_in.hist) begin
                    q_next.done = 1'b1;
                    q_next.idx  = agc_pkg::GROUP_IDX_W'(CELL_INDEX);
                    q_next.pos  = size_reg;
                    if (size_reg != agc_pkg::COUNT_MAX) begin
                        size_next = size_reg + agc_pkg::CNT_W'(1);
                    end
                end
            end else begin
                store          = 1'b1;
                used_next      = 1'b1;
                size_next      = agc_pkg::CNT_W'(1);
                q_next.done    = 1'b1;
                q_next.new_grp = 1'b1;
                q_next.idx     = agc_pkg::GROUP_IDX_W'(CELL_INDEX);
                q_next.pos     = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= 1'b0;
            q_reg.valid <= 1'b0;
        end else if (advance) begin
            used_reg <= used_next;
            q_reg    <= q_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            size_reg <= size_next;
            if (store) begin
                sig_reg <= q_in.hist;
            end
        end
    end

    assign q_out = q_reg;

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for anagram_group_classifier: streams letter items in bursts, predicts each
// word's group verdict and checks every result item in order against that prediction.
// Depends on agc_pkg and the anagram_group_classifier RTL.
module tb_top;

    localparam int N_GROUPS        = 16;
    localparam int WORD_MAX        = 15;
    localparam int N_LETTERS       = 26;
    localparam logic [4:0] NO_LETTER = 5'd31;
    localparam int POOL_SIZE       = 24;
    localparam int RANDOM_ITEMS    = 1500;
    localparam int IDLE_LIMIT      = 3000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER  = 80;

    typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE} stall_mode_t;

    typedef struct {
        agc_pkg::in_item_t item;
        bit                drain;
    } feed_entry_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    agc_pkg::in_item_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    agc_pkg::out_item_t m_data;

    anagram_group_classifier DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    // group verdict predictor
    logic [3:0]         word_hist [N_LETTERS];
    logic [3:0]         known_sig [N_GROUPS][N_LETTERS];
    logic [3:0]         group_members [N_GROUPS];
    int                 groups_open;
    int                 letters_counted;
    agc_pkg::out_item_t verdicts_due [$];

    task automatic classify_letter(input agc_pkg::in_item_t it);
        agc_pkg::out_item_t v;
        int                 hit;
        bit                 same;
        if (it.letter < N_LETTERS && letters_counted < WORD_MAX) begin
            if (word_hist[it.letter] != agc_pkg::COUNT_MAX) word_hist[it.letter] += 4'd1;
            letters_counted++;
        end
        if (!it.word_end) return;
        hit = -1;
        for (int g = 0; g < groups_open && hit < 0; g++) begin
            same = 1'b1;
            for (int l = 0; l < N_LETTERS; l++) begin
                if (known_sig[g][l] != word_hist[l]) same = 1'b0;
            end
            if (same) hit = g;
        end
        v = '0;
        if (hit >= 0) begin
            v.group_index     = hit[3:0];
            v.member_position = group_members[hit];
            if (group_members[hit] != agc_pkg::COUNT_MAX) group_members[hit] += 4'd1;
        end else if (groups_open < N_GROUPS) begin
            for (int l = 0; l < N_LETTERS; l++) known_sig[groups_open][l] = word_hist[l];
            group_members[groups_open] = 4'd1;
            v.group_index = groups_open[3:0];
            v.new_group   = 1'b1;
            groups_open++;
        end else begin
            v.table_full = 1'b1;
        end
        for (int l = 0; l < N_LETTERS; l++) word_hist[l] = '0;
        letters_counted = 0;
        verdicts_due.push_back(v);
    endtask

    // checker and idle watchdog
    int errors       = 0;
    int words_due    = 0;
    int results_seen = 0;
    int idle_cycles  = 0;

    always @(posedge aclk) begin
        agc_pkg::out_item_t want;
        bit                 got;
        bit                 took;
        got  = m_valid && m_ready;
        took = s_valid && s_ready;
        if (aresetn) begin
            if (got) begin
                if (verdicts_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got %0d/%0b/%0d/%0b",
                             $realtime, m_data.group_index, m_data.new_group,
                             m_data.member_position, m_data.table_full);
                end else begin
                    want = verdicts_due.pop_front();
                    if (want !== m_data) begin
                        errors++;
                        $display("%0t: mismatch, expected %0d/%0b/%0d/%0b, got %0d/%0b/%0d/%0b",
                                 $realtime, want.group_index, want.new_group,
                                 want.member_position, want.table_full,
                                 m_data.group_index, m_data.new_group,
                                 m_data.member_position, m_data.table_full);
                    end
                end
            end
            if (took) classify_letter(s_data);
        end
        if (got || took) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
        words_due    <= verdicts_due.size();
        results_seen <= results_seen + int'(got);
    end

    // letter driver
    feed_entry_t letter_feed [$];
    int          burst_left = 0;
    int          gap_left   = 0;

    always @(posedge aclk) begin
        logic              nxt_valid;
        agc_pkg::in_item_t nxt_data;
        feed_entry_t       e;
        nxt_valid = s_valid;
        nxt_data  = s_data;
        if (aresetn && (!s_valid || s_ready)) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (letter_feed.size() > 0) begin
                if (letter_feed[0].drain) begin
                    // hold until every verdict has arrived
                    if (!s_valid && words_due == 0) void'(letter_feed.pop_front());
                end else begin
                    e         = letter_feed.pop_front();
                    nxt_data  = e.item;
                    nxt_valid = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
        s_valid <= nxt_valid;
        s_data  <= nxt_data;
    end

    // result receiver
    stall_mode_t stall_mode = READY_ALWAYS;
    int          mode_left  = 0;
    int          hold_left  = 0;
    bit          hold_done  = 1'b0;

    always @(posedge aclk) begin
        logic nxt_ready;
        if (!hold_done && results_seen >= HOLD_OFF_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            nxt_ready = 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = stall_mode_t'($urandom_range(0, 2));
                mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            case (stall_mode)
                READY_ALWAYS: nxt_ready = 1'b1;
                READY_HALF:   nxt_ready = 1'($urandom_range(0, 1));
                default:      nxt_ready = ($urandom_range(0, 3) == 0);
            endcase
        end
        m_ready <= nxt_ready;
    end

    // stimulus
    logic [4:0] word_buf [$];
    int         items_queued = 0;

    task automatic flush_word();
        feed_entry_t e;
        e.drain = 1'b0;
        if (word_buf.size() == 0) word_buf.push_back(NO_LETTER);
        foreach (word_buf[i]) begin
            e.item.letter   = word_buf[i];
            e.item.word_end = (i == word_buf.size() - 1);
            letter_feed.push_back(e);
        end
        items_queued += word_buf.size();
        word_buf.delete();
    endtask

    initial begin
        logic [4:0]  pool_letters [POOL_SIZE][WORD_MAX];
        int          pool_len [POOL_SIZE];
        feed_entry_t marker;
        int          pick;
        int          n;
        int          k;
        bit          midway_drain;
        logic [4:0]  t;

        for (int l = 0; l < N_LETTERS; l++) word_hist[l] = '0;
        groups_open     = 0;
        letters_counted = 0;
        marker.item     = '0;
        marker.drain    = 1'b1;
        midway_drain    = 1'b0;

        // single letters at both ends of the alphabet
        word_buf.push_back(5'd0);
        flush_word();
        word_buf.push_back(5'd25);
        flush_word();
        // empty word
        word_buf.push_back(NO_LETTER);
        flush_word();
        // out-of-range letter skipped, then a repeat of an existing group
        word_buf.push_back(5'd26);
        word_buf.push_back(5'd0);
        flush_word();
        word_buf.push_back(5'd16);
        word_buf.push_back(5'd25);
        flush_word();
        // overlong word of one letter: length limit and count ceiling
        repeat (18) word_buf.push_back(5'd1);
        flush_word();
        letter_feed.push_back(marker);

        for (int p = 0; p < POOL_SIZE; p++) begin
            pool_len[p] = ($urandom_range(0, 5) == 0) ? WORD_MAX : $urandom_range(1, 8);
            for (int j = 0; j < WORD_MAX; j++) pool_letters[p][j] = 5'($urandom_range(0, 25));
        end

        items_queued = 0;
        while (items_queued < RANDOM_ITEMS) begin
            if (!midway_drain && items_queued >= RANDOM_ITEMS / 2) begin
                letter_feed.push_back(marker);
                midway_drain = 1'b1;
            end
            if ($urandom_range(0, 4) != 0) begin
                // anagram of a pool word
                pick = $urandom_range(0, POOL_SIZE - 1);
                for (int j = 0; j < pool_len[pick]; j++) begin
                    word_buf.push_back(pool_letters[pick][j]);
                end
                for (int j = word_buf.size() - 1; j > 0; j--) begin
                    k           = $urandom_range(0, j);
                    t           = word_buf[j];
                    word_buf[j] = word_buf[k];
                    word_buf[k] = t;
                end
            end else begin
                n = $urandom_range(0, 20);
                for (int j = 0; j < n; j++) begin
                    if ($urandom_range(0, 3) == 0) word_buf.push_back(5'($urandom_range(26, 31)));
                    else word_buf.push_back(5'($urandom_range(0, 25)));
                end
            end
            flush_word();
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (letter_feed.size() != 0 || s_valid) @(posedge aclk);
        while (words_due != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && verdicts_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
